// ===== rtl/hfwm_pkg.sv =====
package hfwm_pkg;

    localparam int SET_BITS   = 10;
    localparam int WAYS       = 4;
    localparam int SET_COUNT  = 1 << SET_BITS;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int COORD_W    = 8;
    localparam int KEY_W      = 3 * COORD_W;
    localparam int VAL_W      = 8;
    localparam int ENTRY_W    = VAL_W + KEY_W;
    localparam int ROW_W      = WAYS * ENTRY_W;
    localparam int HASH_W     = 32;
    localparam int MIX_SHIFT  = 12;
    localparam int HASH_SHIFT = 16;
    localparam int HIT_WAY_W  = 2;

    localparam logic [HASH_W-1:0] HASH_MULT = 32'd65521;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [VAL_W-1:0]    val_t;
    typedef logic [SET_BITS-1:0] set_t;
    typedef logic [WAY_W-1:0]    way_t;

    typedef struct packed {
        val_t value;
        key_t tag;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_LOAD,
        ST_CMP,
        ST_WRITE,
        ST_DONE
    } state_t;

    // head goes to way 0, ways 1..lim take their predecessor, the rest stay
    function automatic row_t reorder(row_t old_row, entry_t head, way_t lim);
        row_t new_row;
        new_row = old_row;
        for (int k = 0; k < WAYS; k++)
        begin
            if (k == 0)
            begin
                new_row[k] = head;
            end
            else if (WAY_W'(k) <= lim)
            begin
                new_row[k] = old_row[k-1];
            end
        end
        return new_row;
    endfunction

endpackage

// ===== rtl/hfwm_ram.sv =====
module hfwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/hfwm_hash.sv =====
module hfwm_hash (
    input  logic           clk,
    input  hfwm_pkg::key_t key,
    output hfwm_pkg::set_t set_idx
);
    import hfwm_pkg::*;

    key_t              mix;
    logic [HASH_W-1:0] prod_next;
    logic [HASH_W-1:0] prod_reg;

    assign mix       = key ^ (key >> MIX_SHIFT);
    assign prod_next = {{(HASH_W-KEY_W){1'b0}}, mix} * HASH_MULT;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign set_idx = prod_reg[HASH_SHIFT +: SET_BITS];

endmodule

// ===== rtl/hashed_four_way_mru_cache.sv =====
// Each transaction steps through hash, RAM read and row load; a fill then writes back, a lookup
// compares ways until a hit (then writes back) or a miss; out_valid follows the done state.
// A new transaction is taken only when the last has finished; a single tag comparator walks
// the ways one per cycle; each transaction reads one row, and writes it back unless it misses.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all SET_COUNT (1024)
// rows of the store, one row per cycle, with in_stall held high.
module hashed_four_way_mru_cache (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  hfwm_pkg::coord_t       cell_x,
    input  hfwm_pkg::coord_t       cell_y,
    input  hfwm_pkg::coord_t       cell_z,
    input  hfwm_pkg::val_t         fill_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output hfwm_pkg::val_t         light_value,
    output logic [1:0]             hit_way
);
    import hfwm_pkg::*;

    state_t state_reg, state_next;
    set_t   clr_cnt_reg;
    way_t   way_reg;
    logic   out_valid_reg;

    logic   op_reg;
    key_t   key_reg;
    val_t   fv_reg;
    row_t   row_reg;
    logic   hit_reg;
    val_t   val_reg;

    logic           hit_out_reg;
    val_t           light_out_reg;
    logic [1:0]     way_out_reg;

    set_t           set_idx;
    entry_t         cur_entry;
    logic           tag_match;
    logic           last_way;
    logic           in_fire;
    logic           out_load;
    logic           ram_we;
    logic           ram_re;
    set_t           ram_waddr;
    row_t           ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    entry_t         head;
    way_t           lim;

    hfwm_hash u_hash (
        .clk     (clk),
        .key     (key_reg),
        .set_idx (set_idx)
    );

    hfwm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (set_idx),
        .rdata (ram_rdata)
    );

    assign in_fire   = in_valid && !in_stall;
    assign cur_entry = row_reg[way_reg];
    assign tag_match = (cur_entry.tag == key_reg);
    assign last_way  = (way_reg == WAY_W'(WAYS - 1));
    assign head      = (op_reg == OP_FILL) ? entry_t'{value: fv_reg, tag: key_reg} : cur_entry;
    assign lim       = (op_reg == OP_FILL) ? WAY_W'(WAYS - 1) : way_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == '1) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_HASH;
            ST_HASH:  state_next = ST_READ;
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD:  state_next = (op_reg == OP_FILL) ? ST_WRITE : ST_CMP;
            ST_CMP:
            begin
                if (tag_match)
                begin
                    state_next = ST_WRITE;
                end
                else if (last_way)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = set_idx;
        ram_wdata = reorder(row_reg, head, lim);
        out_load  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:  in_stall = 1'b0;
            ST_READ:  ram_re = 1'b1;
            ST_WRITE: ram_we = 1'b1;
            ST_DONE:  out_load = !out_valid_reg || !out_stall;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            way_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_LOAD)
            begin
                way_reg <= '0;
            end
            else if (state_reg == ST_CMP && !tag_match && !last_way)
            begin
                way_reg <= way_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= opcode;
            key_reg <= {cell_x, cell_y, cell_z};
            fv_reg  <= fill_value;
        end
        if (state_reg == ST_LOAD)
        begin
            row_reg <= ram_rdata;
            hit_reg <= 1'b0;
            val_reg <= (op_reg == OP_FILL) ? fv_reg : '0;
        end
        if (state_reg == ST_CMP && tag_match)
        begin
            hit_reg <= 1'b1;
            val_reg <= cur_entry.value;
        end
        if (out_load)
        begin
            hit_out_reg   <= hit_reg;
            light_out_reg <= val_reg;
            way_out_reg   <= hit_reg ? HIT_WAY_W'(way_reg) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_out_reg;
    assign light_value = light_out_reg;
    assign hit_way     = way_out_reg;

    a_accept_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_HASH)
        else $error("accepted transaction did not start hashing");

    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("store written outside clear or write-back");

    a_lookup_write_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && op_reg == OP_LOOKUP) |-> hit_reg)
        else $error("lookup wrote back without a hit");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented outside completion");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> in_stall)
        else $error("transaction accepted during clearing pass");

endmodule
